[rtl/b64d_pkg.sv]
`timescale 1ns / 1ps

package b64d_pkg;

  // Padding character '='
  localparam logic [7:0] PAD_CODE = 8'h3D;

  // Byte slots within a decoded group, most significant first
  localparam logic [1:0] SLOT_HI  = 2'd0;
  localparam logic [1:0] SLOT_MID = 2'd1;
  localparam logic [1:0] SLOT_LO  = 2'd2;

  // Character positions within a four-character group
  localparam logic [1:0] POS_LAST = 2'd3;

  // One decoded group handed from the front to the back
  typedef struct packed {
    logic [23:0] word;          // four sextets, first character on top
    logic [1:0]  count;         // bytes to send, 1 to 3
    logic        stream_last;   // group closes the string
    logic        length_error;  // string ended on a partial group
  } group_job_t;

  // Queue occupancy seen by its neighbors
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  // Map a character code to its 6-bit value; '=' and strangers give zero
  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [7:0] diff;
    begin
      diff = 8'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
        diff = c - 8'h41;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        diff = c - 8'h61 + 8'd26;
      end else if (c >= 8'h30 && c <= 8'h39) begin
        diff = c - 8'h30 + 8'd52;
      end else if (c == 8'h2B) begin
        diff = 8'd62;
      end else if (c == 8'h2F) begin
        diff = 8'd63;
      end
      sextet_of = diff[5:0];
    end
  endfunction

endpackage

[rtl/b64d_char_if.sv]
`timescale 1ns / 1ps

interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

[rtl/b64d_byte_if.sv]
`timescale 1ns / 1ps

interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       run_last;
  logic       stream_last;
  logic       length_error;

  modport source (output valid, output byte_value, output run_last,
                  output stream_last, output length_error, input ready);
  modport sink   (input valid, input byte_value, input run_last,
                  input stream_last, input length_error, output ready);
endinterface

[rtl/b64d_front.sv]
`timescale 1ns / 1ps

module b64d_front
  import b64d_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  b64d_char_if.sink     chars,
  input  queue_status_t qstat,
  output logic          push,
  output group_job_t    job
);

  logic [17:0] acc;
  logic [1:0]  pos;
  logic        third_pad;

  logic        take;
  logic        is_pad;
  logic [5:0]  sextet;
  logic        drop_last;
  logic        drop_third;

  // Characters flow whenever the queue has room
  assign chars.ready = !qstat.full;
  assign take        = chars.valid && chars.ready;

  assign is_pad = (chars.char_code == PAD_CODE);
  assign sextet = sextet_of(chars.char_code);

  // A group leaves on its fourth character or on an early end
  assign push = take && ((pos == POS_LAST) || chars.end_of_text);

  assign drop_last  = chars.end_of_text && is_pad;
  assign drop_third = chars.end_of_text && third_pad;

  always_comb begin
    if (pos == POS_LAST) begin
      job.word         = {acc, sextet};
      job.count        = 2'd3 - {1'b0, drop_last} - {1'b0, drop_third};
      job.stream_last  = chars.end_of_text;
      job.length_error = 1'b0;
    end else begin
      // partial group: a single error beat with a zero byte
      job.word         = 24'd0;
      job.count        = 2'd1;
      job.stream_last  = 1'b1;
      job.length_error = 1'b1;
    end
  end

  // Group accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 18'd0;
      pos       <= 2'd0;
      third_pad <= 1'b0;
    end else if (take) begin
      if (push) begin
        acc       <= 18'd0;
        pos       <= 2'd0;
        third_pad <= 1'b0;
      end else begin
        acc <= {acc[11:0], sextet};
        pos <= pos + 2'd1;
        if (pos == 2'd2) begin
          third_pad <= is_pad;
        end
      end
    end
  end

  // A string end always brings the group back to its start
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (take && chars.end_of_text) |=> (pos == 2'd0 && acc == 18'd0))
    else $error("group state not cleared after end of text");

endmodule

[rtl/b64d_queue.sv]
`timescale 1ns / 1ps

module b64d_queue
  import b64d_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  group_job_t    wr_job,
  input  logic          pop,
  output group_job_t    head,
  output queue_status_t qstat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  group_job_t    slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign qstat.empty = (fill == '0);
  assign qstat.full  = (fill == FULL_CNT);
  assign head        = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && qstat.full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && qstat.empty))
    else $error("pop from empty queue");

endmodule

[rtl/b64d_back.sv]
`timescale 1ns / 1ps

module b64d_back
  import b64d_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  group_job_t    head,
  input  queue_status_t qstat,
  output logic          pop,
  b64d_byte_if.source   decoded
);

  logic [1:0] slot;
  logic       take;
  logic       fin;
  logic [7:0] sel_byte;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_stream_last;
  logic       out_err;

  // Load the output register when it is empty or being drained
  assign take = !qstat.empty && (!out_valid || decoded.ready);
  assign fin  = (slot + 2'd1 == head.count);
  assign pop  = take && fin;

  always_comb begin
    case (slot)
      SLOT_HI:  sel_byte = head.word[23:16];
      SLOT_MID: sel_byte = head.word[15:8];
      SLOT_LO:  sel_byte = head.word[7:0];
      default:  sel_byte = 8'd0;
    endcase
  end

  // Byte index within the head group
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= SLOT_HI;
    end else if (take) begin
      slot <= fin ? SLOT_HI : slot + 2'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (decoded.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte        <= sel_byte;
      out_run_last    <= fin;
      out_stream_last <= fin && head.stream_last;
      out_err         <= head.length_error;
    end
  end

  assign decoded.valid        = out_valid;
  assign decoded.byte_value   = out_byte;
  assign decoded.run_last     = out_run_last;
  assign decoded.stream_last  = out_stream_last;
  assign decoded.length_error = out_err;

  a_slot_in_group: assert property (@(posedge clk) disable iff (rst)
    !qstat.empty |-> (slot < head.count))
    else $error("byte index beyond group size");

endmodule

[rtl/base64_decoder.sv]
`timescale 1ns / 1ps

// Channel   Dir  Payload                                          Beat
// chars     in   char_code[7:0], end_of_text                      one character
// decoded   out  byte_value[7:0], run_last, stream_last,          one byte or one
//                length_error                                     length-error mark
//
// One character is taken per cycle; a full group comes out as up to three
// bytes at one byte per cycle, so the sustained rate is one character a cycle.
// Each group is written to the queue, then sent through the output register.
// The group queue (QUEUE_DEPTH entries) lets the character side keep running
// while the byte side is stalled; chars.ready drops only when it is full.
// Reset (rst, synchronous) clears the group state, the queue and the output.

module base64_decoder
  import b64d_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  b64d_char_if.sink   chars,
  b64d_byte_if.source decoded
);

  queue_status_t qstat;
  group_job_t    wr_job;
  group_job_t    head;
  logic          push;
  logic          pop;

  b64d_front u_front (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .qstat (qstat),
    .push  (push),
    .job   (wr_job)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .head   (head),
    .qstat  (qstat)
  );

  b64d_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .qstat   (qstat),
    .pop     (pop),
    .decoded (decoded)
  );

endmodule

[tb/base64_decoder_test.sv]
`timescale 1ns / 1ps

module base64_decoder_test;
  import b64d_pkg::*;

  // Decoded beat as seen on the byte channel
  typedef struct packed {
    logic [7:0] byte_value;
    logic       run_last;
    logic       stream_last;
    logic       length_error;
  } byte_beat_t;

  // One character to send; fixed_n < 0 means the decode model supplies the bytes
  typedef struct {
    logic [7:0]            code;
    logic                  eot;
    int                    fixed_n;
    byte_beat_t [2:0]      fixed_bytes;
  } char_row_t;

  localparam logic [1:0] POS_THIRD = 2'd2;
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic clk = 1'b0;
  logic rst;

  b64d_char_if char_ch ();
  b64d_byte_if byte_ch ();

  base64_decoder DUT (
    .clk     (clk),
    .rst     (rst),
    .chars   (char_ch),
    .decoded (byte_ch)
  );

  always #1 clk = ~clk;

  // Decode model state
  logic [17:0] acc_sextets;
  logic [1:0]  group_pos;
  logic        third_pad;

  byte_beat_t pending_bytes[$];
  char_row_t  directed_rows[$];
  int         error_count = 0;
  int         chars_sent = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  logic       hold_off = 1'b0;

  function automatic void log_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endfunction

  function automatic logic [5:0] sextet_value(input logic [7:0] code);
    int i;
    for (i = 0; i < 64; i++) begin
      if (ALPHABET[8*(63-i) +: 8] == code) return i[5:0];
    end
    return 6'd0;  // pad and strangers
  endfunction

  function automatic byte_beat_t beat(input logic [7:0] b, input logic rl,
                                      input logic sl, input logic le);
    return '{byte_value: b, run_last: rl, stream_last: sl, length_error: le};
  endfunction

  function automatic void clear_group();
    acc_sextets = '0;
    group_pos   = '0;
    third_pad   = 1'b0;
  endfunction

  // Advance the decode state by one character; returns the number of bytes due
  function automatic int decode_char(input logic [7:0] code, input logic eot,
                                     output byte_beat_t res [3]);
    logic [5:0]  s;
    logic [23:0] word;
    int          n;
    int          k;
    s = sextet_value(code);
    for (k = 0; k < 3; k++) res[k] = '0;
    if (group_pos != POS_LAST) begin
      if (eot) begin
        // string ended mid-group
        res[0] = beat(8'h00, 1'b1, 1'b1, 1'b1);
        clear_group();
        return 1;
      end
      if (group_pos == POS_THIRD) third_pad = (code == PAD_CODE);
      acc_sextets = {acc_sextets[11:0], s};
      group_pos   = group_pos + 2'd1;
      return 0;
    end
    word = {acc_sextets, s};
    n = 3;
    if (eot) begin
      if (code == PAD_CODE) n--;
      if (third_pad) n--;
    end
    for (k = 0; k < n; k++) begin
      res[k] = beat(word[23-8*k -: 8], k == n - 1, eot && (k == n - 1), 1'b0);
    end
    clear_group();
    return n;
  endfunction

  function automatic char_row_t plain_row(input logic [7:0] code, input logic eot);
    char_row_t r;
    r.code        = code;
    r.eot         = eot;
    r.fixed_n     = -1;
    r.fixed_bytes = '0;
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] code, input logic eot);
    directed_rows.push_back(plain_row(code, eot));
  endfunction

  function automatic void add_fixed(input logic [7:0] code, input logic eot, input int n,
                                    input byte_beat_t b0, input byte_beat_t b1,
                                    input byte_beat_t b2);
    char_row_t r;
    r = plain_row(code, eot);
    r.fixed_n = n;
    r.fixed_bytes[0] = b0;
    r.fixed_bytes[1] = b1;
    r.fixed_bytes[2] = b2;
    directed_rows.push_back(r);
  endfunction

  // Offer one character, wait for its beat, queue the bytes it should produce
  task automatic put_char(input char_row_t row);
    byte_beat_t res [3];
    int         n;
    int         k;
    while ($urandom_range(99) < send_idle_pct) begin
      char_ch.valid <= 1'b0;
      @(posedge clk);
    end
    char_ch.valid       <= 1'b1;
    char_ch.char_code   <= row.code;
    char_ch.end_of_text <= row.eot;
    @(posedge clk);
    while (!char_ch.ready) @(posedge clk);
    n = decode_char(row.code, row.eot, res);
    if (row.fixed_n >= 0) begin
      n = row.fixed_n;
      for (k = 0; k < 3; k++) res[k] = row.fixed_bytes[k];
    end
    for (k = 0; k < n; k++) pending_bytes.push_back(res[k]);
    chars_sent++;
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(15);
    if (r == 0) return 8'($urandom_range(255));
    if (r == 1) return PAD_CODE;
    return ALPHABET[8*(63 - $urandom_range(63)) +: 8];
  endfunction

  // One random string: mostly well formed, some truncated, some pure noise
  task automatic send_string();
    int         kind;
    int         n_full;
    int         len;
    int         pad_style;
    int         g;
    int         j;
    logic [7:0] c;
    kind = $urandom_range(99);
    if (kind < 10) begin
      len = $urandom_range(1, 8);
      for (j = 0; j < len; j++) put_char(plain_row(8'($urandom_range(255)), j == len - 1));
    end else if (kind < 25) begin
      n_full = $urandom_range(0, 2);
      for (g = 0; g < 4 * n_full; g++) put_char(plain_row(pick_char(), 1'b0));
      len = $urandom_range(1, 3);
      for (j = 0; j < len; j++) put_char(plain_row(pick_char(), j == len - 1));
    end else begin
      n_full = $urandom_range(0, 2);
      for (g = 0; g < 4 * n_full; g++) put_char(plain_row(pick_char(), 1'b0));
      pad_style = $urandom_range(3);
      for (j = 0; j < 4; j++) begin
        c = pick_char();
        case (pad_style)
          1: if (j == 3) c = PAD_CODE;
          2: if (j >= 2) c = PAD_CODE;
          3: begin
            if (j == 2) c = PAD_CODE;
            if (j == 3) c = ALPHABET[8*(63 - $urandom_range(63)) +: 8];
          end
          default: ;
        endcase
        put_char(plain_row(c, j == 3));
      end
    end
  endtask

  task automatic wait_for_bytes(input int max_cycles);
    int n;
    char_ch.valid <= 1'b0;
    n = 0;
    while (pending_bytes.size() != 0 && n < max_cycles) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // Byte side: check each beat, then decide ready for the next edge
  always @(posedge clk) begin : byte_check
    byte_beat_t got;
    byte_beat_t want;
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      got = beat(byte_ch.byte_value, byte_ch.run_last, byte_ch.stream_last,
                 byte_ch.length_error);
      if (pending_bytes.size() == 0) begin
        log_error($sformatf("unexpected beat: byte %02h rl %0b sl %0b le %0b",
                            got.byte_value, got.run_last, got.stream_last,
                            got.length_error));
      end else begin
        want = pending_bytes.pop_front();
        if (got.byte_value !== want.byte_value || got.run_last !== want.run_last ||
            got.stream_last !== want.stream_last ||
            got.length_error !== want.length_error) begin
          log_error($sformatf(
            "mismatch: exp byte %02h rl %0b sl %0b le %0b, got byte %02h rl %0b sl %0b le %0b",
            want.byte_value, want.run_last, want.stream_last, want.length_error,
            got.byte_value, got.run_last, got.stream_last, got.length_error));
        end
      end
    end
    byte_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Hard stop
  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int r;
    int target;
    int ph;
    rst                 = 1'b1;
    char_ch.valid       = 1'b0;
    char_ch.char_code   = 8'h00;
    char_ch.end_of_text = 1'b0;
    byte_ch.ready       = 1'b0;
    clear_group();

    // "TWFu" inside a string decodes to 'M' 'a' 'n'
    add_row("T", 1'b0);
    add_row("W", 1'b0);
    add_row("F", 1'b0);
    add_fixed("u", 1'b0, 3, beat(8'h4D, 1'b0, 1'b0, 1'b0), beat(8'h61, 1'b0, 1'b0, 1'b0),
              beat(8'h6E, 1'b1, 1'b0, 1'b0));
    // pad mid-string, out-of-alphabet codes, '+'
    add_row(PAD_CODE, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'h00, 1'b0);
    add_row("+", 1'b0);
    // all ones, ends the string
    add_row("/", 1'b0);
    add_row("/", 1'b0);
    add_row("/", 1'b0);
    add_fixed("/", 1'b1, 3, beat(8'hFF, 1'b0, 1'b0, 1'b0), beat(8'hFF, 1'b0, 1'b0, 1'b0),
              beat(8'hFF, 1'b1, 1'b1, 1'b0));
    // one-character string: length error
    add_fixed("A", 1'b1, 1, beat(8'h00, 1'b1, 1'b1, 1'b1), '0, '0);
    // single trailing pad: two bytes
    add_row("Q", 1'b0);
    add_row("Q", 1'b0);
    add_row("A", 1'b0);
    add_row(PAD_CODE, 1'b1);
    // pad in third place only: two bytes
    add_row("a", 1'b0);
    add_row("z", 1'b0);
    add_row(PAD_CODE, 1'b0);
    add_row("9", 1'b1);
    // double pad: one zero byte
    add_row("A", 1'b0);
    add_row("A", 1'b0);
    add_row(PAD_CODE, 1'b0);
    add_fixed(PAD_CODE, 1'b1, 1, beat(8'h00, 1'b1, 1'b1, 1'b0), '0, '0);
    // two-character string: length error
    add_row("x", 1'b0);
    add_fixed("y", 1'b1, 1, beat(8'h00, 1'b1, 1'b1, 1'b1), '0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    for (r = 0; r < directed_rows.size(); r++) put_char(directed_rows[r]);

    // sender waits for every byte, then floods a stalled byte side
    wait_for_bytes(5000);
    set_idling(0, 0);
    fork
      begin
        hold_off <= 1'b1;
        repeat (80) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    target = chars_sent + 40;
    while (chars_sent < target) send_string();

    // random strings over the idling mixes
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_idling(0, 0);
        1: set_idling(58, 0);
        2: set_idling(0, 58);
        default: set_idling(30, 30);
      endcase
      target = chars_sent + 50;
      while (chars_sent < target) send_string();
    end

    set_idling(0, 0);
    wait_for_bytes(20000);
    repeat (10) @(posedge clk);
    if (pending_bytes.size() != 0)
      log_error($sformatf("%0d expected bytes never arrived", pending_bytes.size()));
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
